FILE: hdl/dtc_pkg.sv
// Shared types and constants of the decision tree classifier.
package dtc_pkg;

  localparam int FEAT_W      = 32;
  localparam int FEAT_COUNT  = 4;
  localparam int NODE_IDX_W  = 8;
  localparam int CLASS_W     = 8;
  localparam int SEL_W       = 2;
  localparam int MAX_TABLE   = 2 ** NODE_IDX_W;

  localparam logic KIND_WRITE    = 1'b0;
  localparam logic KIND_CLASSIFY = 1'b1;

  typedef struct packed {
    logic [SEL_W-1:0]      feature;
    logic [FEAT_W-1:0]     threshold;
    logic [NODE_IDX_W-1:0] left;
    logic [NODE_IDX_W-1:0] right;
    logic                  leaf;
    logic [CLASS_W-1:0]    cls;
  } node_t;

  typedef logic [FEAT_COUNT-1:0][FEAT_W-1:0] feat_vec_t;

  typedef struct packed {
    logic [CLASS_W-1:0] predicted_class;
    logic               depth_error;
  } result_t;

endpackage

FILE: hdl/dtc_if.sv
// Valid/ready channel interfaces for request and result beats.
interface dtc_item_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [7:0]         node_addr;
  logic [1:0]         node_feature;
  logic signed [31:0] node_threshold;
  logic [7:0]         node_left;
  logic [7:0]         node_right;
  logic               node_leaf;
  logic [7:0]         node_class;
  logic signed [31:0] feat0;
  logic signed [31:0] feat1;
  logic signed [31:0] feat2;
  logic signed [31:0] feat3;

  modport source (
    output valid, kind, node_addr, node_feature, node_threshold, node_left,
           node_right, node_leaf, node_class, feat0, feat1, feat2, feat3,
    input  ready
  );
  modport sink (
    input  valid, kind, node_addr, node_feature, node_threshold, node_left,
           node_right, node_leaf, node_class, feat0, feat1, feat2, feat3,
    output ready
  );
endinterface

interface dtc_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] predicted_class;
  logic       depth_error;

  modport source (output valid, predicted_class, depth_error, input ready);
  modport sink (input valid, predicted_class, depth_error, output ready);
endinterface

FILE: hdl/dtc_node_mem.sv
// Node table: single write port, single read port, registered read data.
module dtc_node_mem import dtc_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  node_t         wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output node_t         rdata
);

  node_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/dtc_walker.sv
// Tree walk sequencer: one node read and one compare per cycle.
module dtc_walker import dtc_pkg::*; #(
  parameter int NODE_COUNT = 256,
  parameter int MAX_DEPTH  = 32,
  parameter int AW         = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  feat_vec_t     start_feats,
  output logic          rd_en,
  output logic [AW-1:0] rd_addr,
  input  node_t         rd_data,
  output logic          idle,
  output logic          done,
  output result_t       result,
  input  logic          res_free
);

  localparam int DW = $clog2(MAX_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_HOLD} state_t;

  state_t              state;
  feat_vec_t           feats;
  logic [DW-1:0]       visited;
  logic [DW-1:0]       visited_next;
  logic signed [31:0]  value;
  logic                go_left;
  logic [NODE_IDX_W-1:0] child;
  logic                depth_hit;
  logic                child_out;

  always_comb begin
    value        = $signed(feats[rd_data.feature]);
    go_left      = value < $signed(rd_data.threshold);
    child        = go_left ? rd_data.left : rd_data.right;
    visited_next = visited + DW'(1);
    depth_hit    = (visited_next == DW'(MAX_DEPTH));
    child_out    = (32'(child) >= NODE_COUNT);
    rd_en        = start ||
                   (state == S_WALK && !rd_data.leaf && !depth_hit && !child_out);
    rd_addr      = start ? '0 : child[AW-1:0];
    idle         = (state == S_IDLE);
    done         = (state == S_HOLD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      visited <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            feats   <= start_feats;
            visited <= '0;
            state   <= S_WALK;
          end
        end
        S_WALK: begin
          if (rd_data.leaf) begin
            result <= '{predicted_class: rd_data.cls, depth_error: 1'b0};
            state  <= S_HOLD;
          end else if (depth_hit || child_out) begin
            result <= '{predicted_class: '0, depth_error: 1'b1};
            state  <= S_HOLD;
          end else begin
            visited <= visited_next;
          end
        end
        S_HOLD: begin
          if (res_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK |-> visited < DW'(MAX_DEPTH))
    else $error("walk depth counter out of range");

  a_start_walks: assert property (@(posedge clk) disable iff (rst)
    start |=> state == S_WALK && visited == '0)
    else $error("classify start did not enter walk");

  a_err_class: assert property (@(posedge clk) disable iff (rst)
    done && result.depth_error |-> result.predicted_class == '0)
    else $error("error result carries nonzero class");

endmodule

FILE: hdl/decision_tree_classifier_core.sv
// Top level: decision tree classifier with loadable node table.
// Write beat: taken when idle; the node lands in the table at the accepting edge.
// Classify beat: walk visits k nodes (1 <= k <= MAX_DEPTH), one table read per cycle;
// then the walker holds its result until the result register is free; loading it reopens input.
// The single read port sets the pace: one node per cycle; a result not yet taken holds input.
// Reset clears control and the result valid flag; the node table is not cleared
// and must be loaded before classifying.
module decision_tree_classifier_core import dtc_pkg::*; #(
  parameter int NODE_COUNT = 256,
  parameter int MAX_DEPTH  = 32
) (
  input logic          clk,
  input logic          rst,
  dtc_item_if.sink     item,
  dtc_result_if.source result
);

  // Only 8-bit node indices arrive, so storage beyond 256 entries is never used.
  localparam int MEM_DEPTH = (NODE_COUNT < MAX_TABLE) ? NODE_COUNT : MAX_TABLE;
  localparam int AW        = $clog2(MEM_DEPTH);

  logic          walk_idle;
  logic          walk_done;
  result_t       walk_res;
  logic          res_free;
  logic          accept;
  logic          start;
  logic          mem_we;
  node_t         wr_node;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  node_t         rd_node;
  feat_vec_t     feats_in;

  // Result register: holds one finished beat so the walker can move on.
  logic    res_valid;
  result_t res_data;

  // Input beats are taken only while no walk is in flight.
  assign item.ready = walk_idle;
  assign accept     = item.valid && item.ready;
  assign start      = accept && (item.kind == KIND_CLASSIFY);
  // Writes beyond the table are dropped.
  assign mem_we     = accept && (item.kind == KIND_WRITE) &&
                      (32'(item.node_addr) < NODE_COUNT);

  assign wr_node = '{feature:   item.node_feature,
                     threshold: item.node_threshold,
                     left:      item.node_left,
                     right:     item.node_right,
                     leaf:      item.node_leaf,
                     cls:       item.node_class};

  assign feats_in = {item.feat3, item.feat2, item.feat1, item.feat0};

  assign res_free = !res_valid || result.ready;

  dtc_node_mem #(
    .DEPTH (MEM_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (item.node_addr[AW-1:0]),
    .wdata (wr_node),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_node)
  );

  dtc_walker #(
    .NODE_COUNT (NODE_COUNT),
    .MAX_DEPTH  (MAX_DEPTH),
    .AW         (AW)
  ) u_walk (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .start_feats (feats_in),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_node),
    .idle        (walk_idle),
    .done        (walk_done),
    .result      (walk_res),
    .res_free    (res_free)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (walk_done && res_free) begin
      res_valid <= 1'b1;
      res_data  <= walk_res;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  assign result.valid           = res_valid;
  assign result.predicted_class = res_data.predicted_class;
  assign result.depth_error     = res_data.depth_error;

  // Table writes never overlap a walk's reads.
  a_no_write_in_walk: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> walk_idle && !rd_en)
    else $error("node table written during a walk");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    walk_done && res_free |=> res_valid)
    else $error("finished walk not loaded into result register");

  a_no_start_while_held: assert property (@(posedge clk) disable iff (rst)
    walk_done |-> !accept)
    else $error("beat accepted while a walk result is pending");

endmodule

FILE: dv/decision_tree_classifier_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the tree classifier: mirrors the node table, predicts and checks results.
module decision_tree_classifier_checker import dtc_pkg::*; #(
  parameter int NODE_COUNT = 256,
  parameter int MAX_DEPTH  = 32
) (
  input  logic  clk,
  input  logic  rst,
  dtc_item_if   item,
  dtc_result_if result,
  output int    fail_count,
  output int    pending
);

  node_t   node_mem [0:MAX_TABLE-1];
  result_t class_q [$];
  int      fails = 0;
  int      pend_cnt = 0;

  assign fail_count = fails;
  assign pending    = pend_cnt;

  // Walk from the root; stop at a leaf, at an index off the table, or at the depth limit.
  function automatic result_t walk_tree(input feat_vec_t fv);
    result_t           res;
    node_t             nd;
    int                idx;
    logic [FEAT_W-1:0] val;
    res.predicted_class = '0;
    res.depth_error     = 1'b1;
    idx = 0;
    for (int visits = 0; visits < MAX_DEPTH; visits++) begin
      if (idx >= NODE_COUNT) break;
      nd = node_mem[idx];
      if (nd.leaf) begin
        res.predicted_class = nd.cls;
        res.depth_error     = 1'b0;
        break;
      end
      val = (int'(nd.feature) < FEAT_COUNT) ? fv[nd.feature] : '0;
      idx = ($signed(val) < $signed(nd.threshold)) ? int'(nd.left) : int'(nd.right);
    end
    return res;
  endfunction

  always @(posedge clk) begin
    result_t want;
    node_t   nd;
    if (!rst) begin
      // results first: a result never belongs to a beat taken on the same edge
      if (result.valid && result.ready) begin
        if (class_q.size() == 0) begin
          $error("result beat with no classify pending: predicted_class %0d depth_error %0b",
                 result.predicted_class, result.depth_error);
          fails++;
        end else begin
          want = class_q.pop_front();
          if (result.predicted_class !== want.predicted_class) begin
            $error("predicted_class: expected %0d, actual %0d",
                   want.predicted_class, result.predicted_class);
            fails++;
          end
          if (result.depth_error !== want.depth_error) begin
            $error("depth_error: expected %0b, actual %0b",
                   want.depth_error, result.depth_error);
            fails++;
          end
        end
      end
      if (item.valid && item.ready) begin
        if (item.kind == KIND_WRITE) begin
          nd.feature   = item.node_feature;
          nd.threshold = item.node_threshold;
          nd.left      = item.node_left;
          nd.right     = item.node_right;
          nd.leaf      = item.node_leaf;
          nd.cls       = item.node_class;
          if (int'(item.node_addr) < NODE_COUNT) node_mem[item.node_addr] = nd;
        end else begin
          class_q.insert(class_q.size(),
                         walk_tree({item.feat3, item.feat2, item.feat1, item.feat0}));
        end
      end
      pend_cnt <= class_q.size();
    end
  end

endmodule

FILE: dv/decision_tree_classifier_core_test.sv
`timescale 1ns / 1ps
// Testbench top for the tree classifier: stimulus, result back-pressure and verdict.
module decision_tree_classifier_core_test import dtc_pkg::*;;

  localparam int NODE_COUNT  = 256;
  localparam int MAX_DEPTH   = 32;
  localparam int ITEM_TARGET = 850;
  // worst case per beat: a full-depth walk, the longest gap and result stalls,
  // plus the long hold; the limit sits well above that total
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int TREE_CAP    = 31;
  localparam logic [7:0] SHARED_LEAF = 8'd200;

  logic clk = 1'b0;
  logic rst;
  int   fail_cnt;
  int   pending_cnt;
  int   cycle_cnt = 0;
  int   beats_sent = 0;
  int   writes_sent = 0;
  int   walks_sent = 0;
  int   burst_left = 0;
  logic offering = 1'b0;    // valid is (or will be, after this edge) high
  logic hold_req = 1'b0;

  // thresholds of the tree now loaded; features are drawn near them
  logic [31:0] thr_pool [0:63];
  int          thr_n = 0;

  dtc_item_if   item_ch ();
  dtc_result_if result_ch ();

  decision_tree_classifier_core #(
    .NODE_COUNT (NODE_COUNT),
    .MAX_DEPTH  (MAX_DEPTH)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  decision_tree_classifier_checker #(
    .NODE_COUNT (NODE_COUNT),
    .MAX_DEPTH  (MAX_DEPTH)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .item       (item_ch),
    .result     (result_ch),
    .fail_count (fail_cnt),
    .pending    (pending_cnt)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // hard stop if the block hangs or a result never shows up
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic node_t mk_node(input logic [1:0] feature, input logic [31:0] thr,
                                    input logic [7:0] left, input logic [7:0] right,
                                    input logic leaf, input logic [7:0] cls);
    node_t nd;
    nd.feature   = feature;
    nd.threshold = thr;
    nd.left      = left;
    nd.right     = right;
    nd.leaf      = leaf;
    nd.cls       = cls;
    return nd;
  endfunction

  function automatic node_t rand_node();
    return mk_node(2'($urandom), $urandom, 8'($urandom), 8'($urandom), 1'($urandom),
                   8'($urandom));
  endfunction

  function automatic feat_vec_t vec(input logic [31:0] f0, input logic [31:0] f1,
                                    input logic [31:0] f2, input logic [31:0] f3);
    return {f3, f2, f1, f0};
  endfunction

  // Three picks in eight hug a current tree threshold (equal, one off) so both branches
  // get hit; the rest are range extremes, that threshold sign-flipped, or plain noise.
  function automatic logic [31:0] pick_value();
    logic [31:0] near;
    near = (thr_n > 0) ? thr_pool[$urandom_range(0, thr_n - 1)] : $urandom;
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return near;
      3:       return near - 32'd1;
      4:       return near + 32'd1;
      5:       return near ^ 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic feat_vec_t rand_feats();
    feat_vec_t fv;
    for (int i = 0; i < FEAT_COUNT; i++) fv[i] = pick_value();
    return fv;
  endfunction

  // One beat on the request channel. Called at a rising edge; returns at the edge
  // that took the beat, or after the gap if the burst ended there.
  task automatic send_beat(input logic kind, input logic [7:0] addr, input node_t nd,
                           input feat_vec_t fv);
    if (!offering) item_ch.valid <= 1'b1;
    offering = 1'b1;
    item_ch.kind           <= kind;
    item_ch.node_addr      <= addr;
    item_ch.node_feature   <= nd.feature;
    item_ch.node_threshold <= nd.threshold;
    item_ch.node_left      <= nd.left;
    item_ch.node_right     <= nd.right;
    item_ch.node_leaf      <= nd.leaf;
    item_ch.node_class     <= nd.cls;
    item_ch.feat0          <= fv[0];
    item_ch.feat1          <= fv[1];
    item_ch.feat2          <= fv[2];
    item_ch.feat3          <= fv[3];
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    beats_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // gap before the next beat, so valid never drops and rises in one step
      item_ch.valid <= 1'b0;
      offering = 1'b0;
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(10, 40)) @(posedge clk);
      else repeat ($urandom_range(1, 4)) @(posedge clk);
      burst_left = $urandom_range(0, 20);
    end
  endtask

  task automatic write_node(input logic [7:0] addr, input node_t nd);
    send_beat(KIND_WRITE, addr, nd, vec($urandom, $urandom, $urandom, $urandom));
    writes_sent++;
  endtask

  task automatic classify(input feat_vec_t fv);
    send_beat(KIND_CLASSIFY, 8'($urandom), rand_node(), fv);
    walks_sent++;
  endtask

  // stop offering and wait until every walk has returned its class
  task automatic wait_drained();
    if (offering) begin
      item_ch.valid <= 1'b0;
      offering = 1'b0;
    end
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
  endtask

  // Random well-formed tree in nodes 0..TREE_CAP-1, laid out breadth first:
  // every inner node points forward, so every walk ends at a leaf.
  task automatic build_tree();
    int    addr_q [$];
    int    dep_q [$];
    int    next_free;
    int    max_dep;
    int    a;
    int    d;
    node_t nd;
    thr_n     = 0;
    next_free = 1;
    max_dep   = $urandom_range(1, 6);
    addr_q.insert(addr_q.size(), 0);
    dep_q.insert(dep_q.size(), 0);
    while (addr_q.size() > 0) begin
      a  = addr_q.pop_front();
      d  = dep_q.pop_front();
      nd = rand_node();
      if (d >= max_dep || next_free + 2 > TREE_CAP || (d > 0 && $urandom_range(0, 3) == 0)) begin
        nd.leaf = 1'b1;
      end else begin
        nd.leaf  = 1'b0;
        nd.left  = 8'(next_free);
        nd.right = 8'(next_free + 1);
        addr_q.insert(addr_q.size(), next_free);
        dep_q.insert(dep_q.size(), d + 1);
        addr_q.insert(addr_q.size(), next_free + 1);
        dep_q.insert(dep_q.size(), d + 1);
        next_free += 2;
        thr_pool[thr_n] = nd.threshold;
        thr_n++;
      end
      write_node(8'(a), nd);
    end
  endtask

  // Chain of inner nodes 0..depth-1 ending in a leaf; a few nodes branch off to a
  // shared leaf. With MAX_DEPTH or more inner nodes the full walk flags the depth error.
  task automatic build_chain(input int depth);
    node_t nd;
    thr_n = 0;
    for (int k = 0; k < depth; k++) begin
      nd       = rand_node();
      nd.leaf  = 1'b0;
      nd.left  = 8'(k + 1);
      nd.right = 8'(k + 1);
      if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 1) == 1) nd.left = SHARED_LEAF;
        else nd.right = SHARED_LEAF;
      end
      thr_pool[thr_n] = nd.threshold;
      thr_n++;
      write_node(8'(k), nd);
    end
    nd      = rand_node();
    nd.leaf = 1'b1;
    write_node(8'(depth), nd);
    nd      = rand_node();
    nd.leaf = 1'b1;
    write_node(SHARED_LEAF, nd);
  endtask

  // Result side: stretches of always-ready, random stalls, and a fixed pattern,
  // plus one long hold-off on request so the block backs up into its input.
  initial begin
    int   mode;
    int   stretch;
    int   tick;
    logic held;
    result_ch.ready <= 1'b0;
    held    = 1'b0;
    mode    = 0;
    stretch = 0;
    tick    = 0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (stretch == 0) begin
        mode    = $urandom_range(0, 2);
        stretch = $urandom_range(30, 200);
      end
      stretch--;
      tick++;
      case (mode)
        0:       result_ch.ready <= 1'b1;
        1:       result_ch.ready <= ($urandom_range(0, 9) > 2);
        default: result_ch.ready <= (tick % 7 > 2);
      endcase
    end
  end

  initial begin
    node_t nd;
    int    episode;
    int    depth;
    int    roll;
    rst                    <= 1'b1;
    item_ch.valid          <= 1'b0;
    item_ch.kind           <= KIND_WRITE;
    item_ch.node_addr      <= '0;
    item_ch.node_feature   <= '0;
    item_ch.node_threshold <= '0;
    item_ch.node_left      <= '0;
    item_ch.node_right     <= '0;
    item_ch.node_leaf      <= 1'b0;
    item_ch.node_class     <= '0;
    item_ch.feat0          <= '0;
    item_ch.feat1          <= '0;
    item_ch.feat2          <= '0;
    item_ch.feat3          <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Load every entry so no walk can ever land on an unwritten node.
    // Nodes 0..MAX_DEPTH-2 form a straight chain, node MAX_DEPTH-1 is its leaf:
    // the longest walk that still succeeds. The rest is random content.
    for (int a = 0; a < NODE_COUNT; a++) begin
      nd = rand_node();
      if (a < MAX_DEPTH - 1) begin
        nd.leaf  = 1'b0;
        nd.left  = 8'(a + 1);
        nd.right = 8'(a + 1);
      end else if (a == MAX_DEPTH - 1) begin
        nd.leaf = 1'b1;
      end
      write_node(8'(a), nd);
    end

    // leaf reached on the last allowed visit
    classify(rand_feats());
    // chain end turned inner and pointed back at the root: walk runs out of depth
    write_node(8'(MAX_DEPTH - 1), mk_node(2'd0, 32'h0, 8'd0, 8'd0, 1'b0, 8'd0));
    classify(rand_feats());
    // root is itself a leaf: one visit
    write_node(8'd0, mk_node(2'd3, $urandom, 8'd255, 8'd255, 1'b1, 8'hA5));
    classify(rand_feats());

    // single compare at the root, class 0 on the left, class 255 on the right
    write_node(8'd1, mk_node(2'd0, 32'h0, 8'd0, 8'd0, 1'b1, 8'h00));
    write_node(8'd255, mk_node(2'd0, 32'h0, 8'd0, 8'd0, 1'b1, 8'hFF));
    // feature 0, most negative threshold: equal value is not below, goes right
    write_node(8'd0, mk_node(2'd0, 32'h8000_0000, 8'd1, 8'd255, 1'b0, 8'd0));
    classify(vec(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    // feature 1, most positive threshold: equal goes right, one less goes left
    write_node(8'd0, mk_node(2'd1, 32'h7fff_ffff, 8'd1, 8'd255, 1'b0, 8'd0));
    classify(vec(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000));
    classify(vec(32'h7fff_ffff, 32'h7fff_fffe, 32'h7fff_ffff, 32'h7fff_ffff));
    // feature 2, threshold 0: -1 must compare signed and go left
    write_node(8'd0, mk_node(2'd2, 32'h0, 8'd1, 8'd255, 1'b0, 8'd0));
    classify(vec(32'h0, 32'h0, 32'hffff_ffff, 32'h0));
    classify(vec(32'hffff_ffff, 32'hffff_ffff, 32'h0, 32'hffff_ffff));
    // feature 3, threshold -5: extremes on both sides
    write_node(8'd0, mk_node(2'd3, 32'hffff_fffb, 8'd1, 8'd255, 1'b0, 8'd0));
    classify(vec(32'h0, 32'h0, 32'h0, 32'h8000_0000));
    classify(vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff));

    // Random episodes: mostly fresh well-formed trees then walks through them, some
    // chains (some near the depth limit), raw node writes (loops likely), walks alone.
    episode = 0;
    while (beats_sent < ITEM_TARGET) begin
      roll = $urandom_range(0, 99);
      // long result hold-off while beats keep coming
      if (episode == 8) hold_req <= 1'b1;
      // sender pause until every walk has returned
      if (episode == 16) wait_drained();
      if (roll < 55) begin
        build_tree();
        repeat ($urandom_range(3, 10)) classify(rand_feats());
      end else if (roll < 67) begin
        depth = ($urandom_range(0, 3) == 0) ? $urandom_range(MAX_DEPTH - 4, MAX_DEPTH + 2)
                                            : $urandom_range(1, 16);
        build_chain(depth);
        repeat ($urandom_range(3, 6)) classify(rand_feats());
      end else if (roll < 80) begin
        thr_n = 0;
        repeat ($urandom_range(1, 4)) write_node(8'($urandom), rand_node());
        repeat (2) classify(rand_feats());
      end else begin
        repeat ($urandom_range(5, 15)) classify(rand_feats());
      end
      episode++;
    end

    wait_drained();
    repeat (MAX_DEPTH + 8) @(posedge clk);
    $display("Covered %0d node writes and %0d tree walks: signed edges, leaf at root,",
             writes_sent, walks_sent);
    $display("full-depth and over-depth walks, random trees, long result stall.");
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: decision_tree_classifier_core.f
hdl/dtc_pkg.sv
hdl/dtc_if.sv
hdl/dtc_node_mem.sv
hdl/dtc_walker.sv
hdl/decision_tree_classifier_core.sv
dv/decision_tree_classifier_checker.sv
dv/decision_tree_classifier_core_test.sv
